// ===== hw/rtl/pgn_pkg.sv =====
// Package for the pixel Gaussian noise injector.
// Shared widths, payload and lane types, and the configuration register indexes.
// No dependencies.
package pgn_pkg;

  // Number of channel fields that one item carries.
  localparam int LANES        = 4;
  // Default for the top-level channel limit.
  localparam int MAX_CHANNELS = 4;

  localparam int SRC_W   = 8;
  localparam int LVL_W   = 9;
  localparam int GAUSS_W = 16;
  localparam int CNT_W   = 3;
  localparam int CFG_W   = LVL_W;
  localparam int IDX_W   = 3;

  // Fixed-point bookkeeping: results are in units of 2^-FRAC_BITS.
  localparam int FRAC_BITS = 19;
  localparam int NOISE_SCALE = 127;
  localparam int PROD_W  = LVL_W + 1 + GAUSS_W;   // level * sample, signed
  localparam int TERM_W  = PROD_W + SRC_W + 1;    // times src or 127, signed
  localparam int SUM_W   = TERM_W + 1;
  localparam int Q_W     = SUM_W - FRAC_BITS;

  typedef logic        [SRC_W-1:0]   src_t;
  typedef logic        [LVL_W-1:0]   lvl_t;
  typedef logic signed [GAUSS_W-1:0] gauss_t;
  typedef logic        [CNT_W-1:0]   cnt_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_INDEPENDENT = 3'd0,
    CFG_CORRELATED  = 3'd1,
    CFG_CHAN_COUNT  = 3'd2,
    CFG_LEVEL_0     = 3'd3,
    CFG_LEVEL_1     = 3'd4,
    CFG_LEVEL_2     = 3'd5,
    CFG_LEVEL_3     = 3'd6
  } cfg_idx_e;

  // Operands for one lane, selected at the top level.
  typedef struct packed {
    src_t   src;
    lvl_t   lvl;     // level used for the noise (own or channel 0)
    gauss_t gauss;   // sample used for the noise (own or channel 0)
    logic   pass;    // own level is zero: source goes through
    logic   act;     // channel lies below the channel count
  } lane_in_t;

  typedef struct packed {
    src_t val;
    logic act;
  } lane_out_t;

  // Per-stage load strobes of the lane pipeline.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ld_t;

endpackage

// ===== hw/rtl/pgn_in_if.sv =====
// Input channel of the noise injector: one pixel and its four noise samples.
// Depends on pgn_pkg.
interface pgn_in_if;
  import pgn_pkg::*;

  logic   valid;
  logic   ready;
  src_t   chan_0;
  src_t   chan_1;
  src_t   chan_2;
  src_t   chan_3;
  gauss_t gauss_0;
  gauss_t gauss_1;
  gauss_t gauss_2;
  gauss_t gauss_3;

  modport source (
    output valid, chan_0, chan_1, chan_2, chan_3,
    output gauss_0, gauss_1, gauss_2, gauss_3,
    input  ready
  );

  modport sink (
    input  valid, chan_0, chan_1, chan_2, chan_3,
    input  gauss_0, gauss_1, gauss_2, gauss_3,
    output ready
  );
endinterface

// ===== hw/rtl/pgn_out_if.sv =====
// Output channel of the noise injector: one noised pixel.
// Depends on pgn_pkg.
interface pgn_out_if;
  import pgn_pkg::*;

  logic valid;
  logic ready;
  src_t out_0;
  src_t out_1;
  src_t out_2;
  src_t out_3;

  modport source (
    output valid, out_0, out_1, out_2, out_3,
    input  ready
  );

  modport sink (
    input  valid, out_0, out_1, out_2, out_3,
    output ready
  );
endinterface

// ===== hw/rtl/pixel_gaussian_noise_injector.sv =====
// Top level of the pixel Gaussian noise injector: config registers, noise
// selection, lane pipeline control. Depends on pgn_pkg, pgn_in_if, pgn_out_if,
// pgn_lane, pgn_merge.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+----------------------------------------
//   in_i     | in  | valid/ready   | chan_0..3 (8b), gauss_0..3 (16b Q4.11)
//   out_o    | out | valid/ready   | out_0..3 (8b)
//   cfg      | in  | cfg_we_i      | cfg_idx_i (3b), cfg_data_i (9b)
//
// One item per cycle sustained while out_o is ready; the registers are the two
// multiplier stages per lane, the round/clamp stage, then the merge register.
// Reset clears the pipeline valid bits and loads the register defaults.
// Each stage holds its item while the next one is full; a bubble anywhere lets
// the stages behind it move up, so input is taken while a result waits.
module pixel_gaussian_noise_injector #(
  parameter int MaxChannels = pgn_pkg::MAX_CHANNELS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  pgn_in_if.sink                   in_i,
  pgn_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [pgn_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [pgn_pkg::CFG_W-1:0] cfg_data_i
);
  import pgn_pkg::*;

  // configuration registers
  logic indep_q, corr_q;
  cnt_t cnt_q;
  lvl_t level_q [LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      indep_q    <= 1'b1;
      corr_q     <= 1'b0;
      cnt_q      <= CNT_W'(3);
      level_q[0] <= LVL_W'(51);
      level_q[1] <= LVL_W'(51);
      level_q[2] <= LVL_W'(51);
      level_q[3] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INDEPENDENT: indep_q    <= cfg_data_i[0];
        CFG_CORRELATED:  corr_q     <= cfg_data_i[0];
        CFG_CHAN_COUNT:  cnt_q      <= cfg_data_i[CNT_W-1:0];
        CFG_LEVEL_0:     level_q[0] <= cfg_data_i;
        CFG_LEVEL_1:     level_q[1] <= cfg_data_i;
        CFG_LEVEL_2:     level_q[2] <= cfg_data_i;
        CFG_LEVEL_3:     level_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective count, saturated at the channel limit
  cnt_t n_eff;
  assign n_eff = (cnt_q > CNT_W'(MaxChannels)) ? CNT_W'(MaxChannels) : cnt_q;

  // noise source per lane: own sample, or channel 0's noise when shared
  src_t     src_v   [LANES];
  gauss_t   gauss_v [LANES];
  lane_in_t lane_in [LANES];

  assign src_v[0] = in_i.chan_0;
  assign src_v[1] = in_i.chan_1;
  assign src_v[2] = in_i.chan_2;
  assign src_v[3] = in_i.chan_3;
  assign gauss_v[0] = in_i.gauss_0;
  assign gauss_v[1] = in_i.gauss_1;
  assign gauss_v[2] = in_i.gauss_2;
  assign gauss_v[3] = in_i.gauss_3;

  always_comb begin
    logic own;
    for (int b = 0; b < LANES; b++) begin
      // alpha channel is the second of two or the fourth of four
      own = (b == 0) || indep_q
         || ((b == 1) && (n_eff == CNT_W'(2)))
         || ((b == 3) && (n_eff == CNT_W'(4)));
      lane_in[b].src   = src_v[b];
      lane_in[b].lvl   = own ? level_q[b] : level_q[0];
      lane_in[b].gauss = own ? gauss_v[b] : gauss_v[0];
      lane_in[b].pass  = (level_q[b] == '0);
      lane_in[b].act   = (CNT_W'(b) < n_eff);
    end
  end

  // pipeline valid bits and load chain
  logic     v1_q, v2_q, v3_q;
  logic     load4;
  pipe_ld_t ld;

  assign ld.ld3 = !v3_q || load4;
  assign ld.ld2 = !v2_q || ld.ld3;
  assign ld.ld1 = !v1_q || ld.ld2;
  assign in_i.ready = ld.ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld.ld1) v1_q <= in_i.valid;
      if (ld.ld2) v2_q <= v1_q;
      if (ld.ld3) v3_q <= v2_q;
    end
  end

  // lanes up to the channel limit; the rest read as unused
  lane_out_t lane_res [LANES];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    if (g < MaxChannels) begin : g_on
      pgn_lane u_lane (
        .clk_i        (clk_i),
        .ld_i         (ld),
        .correlated_i (corr_q),
        .lane_i       (lane_in[g]),
        .lane_o       (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = '0;
    end
  end

  pgn_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .load_o  (load4),
    .res_i   (lane_res),
    .out_o   (out_o)
  );

  // a blocked last lane stage keeps its item
  a_hold_v3 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !load4) |=> v3_q)
    else $error("lane stage 3 dropped a stalled item");

  // a result only appears when the lanes had one ready
  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(v3_q))
    else $error("output valid without a lane result");

  // input is refused only when every stage is full
  a_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && out_o.valid))
    else $error("input refused with a free stage");

endmodule

// ===== hw/rtl/pgn_lane.sv =====
// One channel lane: level*sample, scaling by 127 or by src, round and clamp.
// Three register stages; loads come from the top-level pipeline control.
// Depends on pgn_pkg.
module pgn_lane (
  input  logic               clk_i,
  input  pgn_pkg::pipe_ld_t  ld_i,
  input  logic               correlated_i,
  input  pgn_pkg::lane_in_t  lane_i,
  output pgn_pkg::lane_out_t lane_o
);
  import pgn_pkg::*;

  localparam int PAD_W = SUM_W - SRC_W - FRAC_BITS;

  // stage 1: level * sample
  logic signed [PROD_W-1:0] prod_d, prod_q;
  src_t                     src1_q;
  logic                     pass1_q, act1_q;

  assign prod_d = $signed({1'b0, lane_i.lvl}) * lane_i.gauss;

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      prod_q  <= prod_d;
      src1_q  <= lane_i.src;
      pass1_q <= lane_i.pass;
      act1_q  <= lane_i.act;
    end
  end

  // stage 2: speckle scales by src, additive by 127
  src_t                     mul_op;
  logic signed [TERM_W-1:0] term_d, term_q;
  src_t                     src2_q;
  logic                     pass2_q, act2_q;

  assign mul_op = correlated_i ? src1_q : SRC_W'(NOISE_SCALE);
  assign term_d = prod_q * $signed({1'b0, mul_op});

  always_ff @(posedge clk_i) begin
    if (ld_i.ld2) begin
      term_q  <= term_d;
      src2_q  <= src1_q;
      pass2_q <= pass1_q;
      act2_q  <= act1_q;
    end
  end

  // stage 3: add source, round half up, floor, clamp
  logic signed [SUM_W-1:0] sum;
  logic signed [Q_W-1:0]   quo;
  src_t                    clamp;
  lane_out_t               res_d, res_q;

  always_comb begin
    sum = $signed({{PAD_W{1'b0}}, src2_q, {FRAC_BITS{1'b0}}})
        + SUM_W'(term_q)
        + $signed(SUM_W'(1) << (FRAC_BITS - 1));
    quo = sum[SUM_W-1:FRAC_BITS];
    if (quo < 0) begin
      clamp = '0;
    end else if (quo > $signed(Q_W'({SRC_W{1'b1}}))) begin
      clamp = '1;
    end else begin
      clamp = quo[SRC_W-1:0];
    end
    res_d.val = pass2_q ? src2_q : clamp;
    res_d.act = act2_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld3) begin
      res_q <= res_d;
    end
  end

  assign lane_o = res_q;

endmodule

// ===== hw/rtl/pgn_merge.sv =====
// Merge stage: gathers the lane results into the output register.
// Channels at or above the count read as zero. Depends on pgn_pkg, pgn_out_if.
module pgn_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               load_o,
  input  pgn_pkg::lane_out_t res_i [pgn_pkg::LANES],
  pgn_out_if.source          out_o
);
  import pgn_pkg::*;

  logic valid_q;
  src_t data_d [LANES];
  src_t data_q [LANES];

  // output register takes a new item when empty or being drained
  assign load_o = !valid_q || out_o.ready;

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      data_d[b] = res_i[b].act ? res_i[b].val : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      data_q <= data_d;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.out_0 = data_q[0];
  assign out_o.out_1 = data_q[1];
  assign out_o.out_2 = data_q[2];
  assign out_o.out_3 = data_q[3];

endmodule
